[rtl/omp_pkg.sv]
// Shared types and constants for the OSC message parser.
package omp_pkg;

  typedef enum logic [3:0] {
    PH_LEN      = 4'd0,
    PH_ADDR     = 4'd1,
    PH_ADDR_PAD = 4'd2,
    PH_COMMA    = 4'd3,
    PH_TAGS     = 4'd4,
    PH_TAGS_PAD = 4'd5,
    PH_WORD     = 4'd6,
    PH_STR      = 4'd7,
    PH_STR_PAD  = 4'd8,
    PH_BLOB     = 4'd9,
    PH_BLOB_PAD = 4'd10,
    PH_DONE     = 4'd11,
    PH_SKIP     = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    TC_INT   = 3'd0,
    TC_FLOAT = 3'd1,
    TC_STR   = 3'd2,
    TC_BLOB  = 3'd3,
    TC_TRUE  = 3'd4,
    TC_FALSE = 3'd5,
    TC_NIL   = 3'd6,
    TC_OTHER = 3'd7
  } tag_t;

  localparam logic [3:0] TK_ADDR_CHAR = 4'd0;
  localparam logic [3:0] TK_ADDR_END  = 4'd1;
  localparam logic [3:0] TK_INT       = 4'd2;
  localparam logic [3:0] TK_FLOAT     = 4'd3;
  localparam logic [3:0] TK_STR_CHAR  = 4'd4;
  localparam logic [3:0] TK_STR_END   = 4'd5;
  localparam logic [3:0] TK_BLOB_BYTE = 4'd6;
  localparam logic [3:0] TK_BLOB_END  = 4'd7;
  localparam logic [3:0] TK_TRUE      = 4'd8;
  localparam logic [3:0] TK_FALSE     = 4'd9;
  localparam logic [3:0] TK_NIL       = 4'd10;
  localparam logic [3:0] TK_MSG_END   = 4'd11;
  localparam logic [3:0] TK_ERROR     = 4'd12;

  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Controller to datapath: one token to place in the staging register.
  typedef struct packed {
    logic        emit;
    logic [3:0]  kind;
    logic        use_word;
    logic        use_byte;
    logic        use_total;
  } tok_cmd_t;

  function automatic tag_t tag_code(input logic [7:0] c);
    tag_t r;
    r = TC_OTHER;
    unique case (c)
      8'h69:   r = TC_INT;
      8'h66:   r = TC_FLOAT;
      8'h73:   r = TC_STR;
      8'h62:   r = TC_BLOB;
      8'h54:   r = TC_TRUE;
      8'h46:   r = TC_FALSE;
      8'h4E:   r = TC_NIL;
      default: r = TC_OTHER;
    endcase
    return r;
  endfunction

endpackage

[rtl/omp_tag_ram.sv]
// Generic RAM with one write port, one read port and registered read.
module omp_tag_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/omp_datapath.sv]
// Datapath: word assembly, counters, tag store, staging and output registers.
module omp_datapath #(
  parameter int MAX_TAGS = 16,
  parameter int AW       = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1,
  parameter int CW       = $clog2(MAX_TAGS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        byte_i,
  input  logic              acc_shift,
  input  logic              acc_clear,
  input  logic              len_load,
  input  logic              bl_dec,
  input  logic              blob_load,
  input  logic              blob_dec,
  input  logic              tags_clear,
  input  logic              tag_push,
  input  logic              cur_inc,
  input  logic [AW-1:0]     rd_addr,
  input  omp_pkg::tok_cmd_t tok,
  input  logic              push,
  input  logic              push_last,
  input  logic              out_take,
  output logic [31:0]       acc_next,
  output logic [31:0]       bytes_left,
  output logic [31:0]       blob_left,
  output logic [CW-1:0]     tag_total,
  output logic [CW-1:0]     tag_cursor,
  output omp_pkg::tag_t     rd_tag,
  output logic              stg_valid,
  output logic              out_valid,
  output logic [3:0]        out_kind,
  output logic [31:0]       out_value,
  output logic [4:0]        out_arg,
  output logic              out_last
);
  logic [31:0]   acc_r;
  logic [31:0]   bl_r, blob_r;
  logic [CW-1:0] tot_r, cur_r;
  logic          sv_r;
  logic [3:0]    sk_r;
  logic [31:0]   sval_r;
  logic [4:0]    sarg_r;
  logic          ov_r, ol_r;
  logic [3:0]    ok_r;
  logic [31:0]   oval_r;
  logic [4:0]    oarg_r;
  logic [2:0]    rdata;
  logic [4:0]    argn;
  logic [31:0]   val;

  assign acc_next   = {acc_r[23:0], byte_i};
  assign bytes_left = bl_r;
  assign blob_left  = blob_r;
  assign tag_total  = tot_r;
  assign tag_cursor = cur_r;
  assign rd_tag     = omp_pkg::tag_t'(rdata);
  assign stg_valid  = sv_r;

  omp_tag_ram #(.WIDTH(3), .DEPTH(MAX_TAGS), .AW(AW)) u_ram (
    .clk(clk), .we(tag_push), .waddr(tot_r[AW-1:0]),
    .wdata(omp_pkg::tag_code(byte_i)), .raddr(rd_addr), .rdata(rdata)
  );

  always_comb begin
    val = 32'd0;
    if (tok.use_word) begin
      val = acc_next;
    end else if (tok.use_byte) begin
      val = {24'd0, byte_i};
    end
    argn = tok.use_total ? 5'(tot_r) : 5'(cur_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      bl_r   <= '0;
      blob_r <= '0;
      tot_r  <= '0;
      cur_r  <= '0;
      sv_r   <= 1'b0;
      sk_r   <= '0;
      sval_r <= '0;
      sarg_r <= '0;
      ov_r   <= 1'b0;
      ok_r   <= '0;
      oval_r <= '0;
      oarg_r <= '0;
      ol_r   <= 1'b0;
    end else begin
      if (acc_clear) begin
        acc_r <= '0;
      end else if (acc_shift) begin
        acc_r <= acc_next;
      end
      if (len_load) begin
        bl_r <= acc_next;
      end else if (bl_dec && bl_r != 32'd0) begin
        bl_r <= bl_r - 32'd1;
      end
      if (blob_load) begin
        blob_r <= acc_next;
      end else if (blob_dec && blob_r != 32'd0) begin
        blob_r <= blob_r - 32'd1;
      end
      if (tags_clear) begin
        tot_r <= '0;
        cur_r <= '0;
      end else begin
        if (tag_push) begin
          tot_r <= tot_r + CW'(1);
        end
        if (cur_inc) begin
          cur_r <= cur_r + CW'(1);
        end
      end
      if (tok.emit) begin
        sv_r   <= 1'b1;
        sk_r   <= tok.kind;
        sval_r <= val;
        sarg_r <= argn;
      end else if (push) begin
        sv_r <= 1'b0;
      end
      if (push) begin
        ov_r   <= 1'b1;
        ok_r   <= sk_r;
        oval_r <= sval_r;
        oarg_r <= sarg_r;
        ol_r   <= push_last;
      end else if (out_take) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_value = oval_r;
  assign out_arg   = oarg_r;
  assign out_last  = ol_r;
endmodule

[rtl/omp_ctrl.sv]
// Controller state machine for the OSC message parser.
module omp_ctrl #(
  parameter int MAX_TAGS = 16,
  parameter int AW       = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1,
  parameter int CW       = $clog2(MAX_TAGS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        byte_i,
  input  logic              out_free,
  input  logic              stg_valid,
  input  logic [31:0]       acc_next,
  input  logic [31:0]       bytes_left,
  input  logic [31:0]       blob_left,
  input  logic [CW-1:0]     tag_total,
  input  logic [CW-1:0]     tag_cursor,
  input  omp_pkg::tag_t     rd_tag,
  output logic              acc_shift,
  output logic              acc_clear,
  output logic              len_load,
  output logic              bl_dec,
  output logic              blob_load,
  output logic              blob_dec,
  output logic              tags_clear,
  output logic              tag_push,
  output logic              cur_inc,
  output logic [AW-1:0]     rd_addr,
  output omp_pkg::tok_cmd_t tok,
  output logic              push,
  output logic              push_last
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_BEND  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_ADV   = 5'b01000,
    S_CLOSE = 5'b10000
  } st_t;

  st_t              st_r, st_nxt;
  omp_pkg::phase_t  ph_r, ph_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             close_r, close_nxt;
  logic             al_r, al_nxt;
  logic             take;
  logic             aligned;
  logic             closing;
  logic             go_adv;
  logic             need_bend;
  logic             finish;
  omp_pkg::phase_t  ph_b;
  logic             cur_ok;
  logic             can_stage;

  assign can_stage = !stg_valid || out_free;
  assign in_ready  = (st_r == S_IDLE) && can_stage;
  assign take      = in_valid && in_ready;
  assign aligned   = (pos_r == 2'd3);
  assign cur_ok    = (tag_cursor < tag_total) && (tag_cursor < CW'(MAX_TAGS));
  assign rd_addr   = tag_cursor[AW-1:0];

  always_comb begin
    st_nxt     = st_r;
    ph_nxt     = ph_r;
    pos_nxt    = pos_r;
    close_nxt  = close_r;
    al_nxt     = al_r;
    acc_shift  = 1'b0;
    acc_clear  = 1'b0;
    len_load   = 1'b0;
    bl_dec     = 1'b0;
    blob_load  = 1'b0;
    blob_dec   = 1'b0;
    tags_clear = 1'b0;
    tag_push   = 1'b0;
    cur_inc    = 1'b0;
    tok        = '0;
    push       = 1'b0;
    push_last  = 1'b0;
    go_adv     = 1'b0;
    need_bend  = 1'b0;
    finish     = 1'b0;
    ph_b       = ph_r;
    closing    = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (stg_valid && out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
        end
        if (take) begin
          pos_nxt = pos_r + 2'd1;
          al_nxt  = aligned;
          closing = (ph_r != omp_pkg::PH_LEN) && (bytes_left <= 32'd1);
          bl_dec  = (ph_r != omp_pkg::PH_LEN);
          unique case (ph_r)
            omp_pkg::PH_LEN: begin
              acc_shift = 1'b1;
              if (aligned) begin
                acc_clear  = 1'b1;
                tags_clear = 1'b1;
                if (acc_next == 32'd0) begin
                  tok.emit = 1'b1; tok.kind = omp_pkg::TK_ERROR;
                end else begin
                  len_load = 1'b1;
                  ph_b     = omp_pkg::PH_ADDR;
                end
              end
            end
            omp_pkg::PH_ADDR: begin
              tok.emit = 1'b1;
              if (byte_i != 8'd0) begin
                tok.kind = omp_pkg::TK_ADDR_CHAR; tok.use_byte = 1'b1;
              end else begin
                tok.kind = omp_pkg::TK_ADDR_END;
                ph_b = aligned ? omp_pkg::PH_COMMA : omp_pkg::PH_ADDR_PAD;
              end
            end
            omp_pkg::PH_ADDR_PAD: begin
              if (aligned) ph_b = omp_pkg::PH_COMMA;
            end
            omp_pkg::PH_COMMA: begin
              if (byte_i == omp_pkg::CH_COMMA) begin
                ph_b = omp_pkg::PH_TAGS;
              end else begin
                tok.emit = 1'b1; tok.kind = omp_pkg::TK_ERROR;
                ph_b = omp_pkg::PH_SKIP;
              end
            end
            omp_pkg::PH_TAGS: begin
              if (byte_i == 8'd0) begin
                if (aligned) go_adv = 1'b1;
                else ph_b = omp_pkg::PH_TAGS_PAD;
              end else if (tag_total >= CW'(MAX_TAGS)) begin
                tok.emit = 1'b1; tok.kind = omp_pkg::TK_ERROR;
                ph_b = omp_pkg::PH_SKIP;
              end else begin
                tag_push = 1'b1;
              end
            end
            omp_pkg::PH_TAGS_PAD, omp_pkg::PH_STR_PAD, omp_pkg::PH_BLOB_PAD: begin
              if (aligned) go_adv = 1'b1;
            end
            omp_pkg::PH_WORD: begin
              acc_shift = 1'b1;
              if (aligned) begin
                acc_clear = 1'b1;
                if (cur_ok && rd_tag == omp_pkg::TC_BLOB) begin
                  blob_load = 1'b1;
                  if (acc_next == 32'd0) begin
                    tok.emit = 1'b1; tok.kind = omp_pkg::TK_BLOB_END;
                    cur_inc = 1'b1; go_adv = 1'b1;
                  end else begin
                    ph_b = omp_pkg::PH_BLOB;
                  end
                end else begin
                  tok.emit = 1'b1; tok.use_word = 1'b1;
                  tok.kind = (cur_ok && rd_tag == omp_pkg::TC_FLOAT) ?
                             omp_pkg::TK_FLOAT : omp_pkg::TK_INT;
                  cur_inc = 1'b1; go_adv = 1'b1;
                end
              end
            end
            omp_pkg::PH_STR: begin
              tok.emit = 1'b1;
              if (byte_i != 8'd0) begin
                tok.kind = omp_pkg::TK_STR_CHAR; tok.use_byte = 1'b1;
              end else begin
                tok.kind = omp_pkg::TK_STR_END;
                cur_inc = 1'b1;
                if (aligned) go_adv = 1'b1;
                else ph_b = omp_pkg::PH_STR_PAD;
              end
            end
            omp_pkg::PH_BLOB: begin
              tok.emit = 1'b1; tok.kind = omp_pkg::TK_BLOB_BYTE; tok.use_byte = 1'b1;
              blob_dec  = 1'b1;
              need_bend = (blob_left <= 32'd1);
            end
            default: begin
            end
          endcase
          ph_nxt    = ph_b;
          close_nxt = closing;
          if (need_bend) begin
            st_nxt = S_BEND;
          end else if (go_adv) begin
            st_nxt = S_LOOK;
          end else if (closing) begin
            st_nxt = S_CLOSE;
          end
        end
      end
      S_BEND: begin
        if (can_stage) begin
          push     = stg_valid;
          tok.emit = 1'b1; tok.kind = omp_pkg::TK_BLOB_END;
          cur_inc  = 1'b1;
          if (al_r) begin
            st_nxt = S_LOOK;
          end else begin
            ph_nxt = omp_pkg::PH_BLOB_PAD;
            st_nxt = close_r ? S_CLOSE : S_IDLE;
          end
        end
      end
      S_LOOK: begin
        st_nxt = S_ADV;
      end
      S_ADV: begin
        if (!cur_ok) begin
          ph_nxt = omp_pkg::PH_DONE;
          st_nxt = close_r ? S_CLOSE : S_IDLE;
        end else if (rd_tag == omp_pkg::TC_INT || rd_tag == omp_pkg::TC_FLOAT ||
                     rd_tag == omp_pkg::TC_BLOB) begin
          acc_clear = 1'b1;
          ph_nxt = omp_pkg::PH_WORD;
          st_nxt = close_r ? S_CLOSE : S_IDLE;
        end else if (rd_tag == omp_pkg::TC_STR) begin
          ph_nxt = omp_pkg::PH_STR;
          st_nxt = close_r ? S_CLOSE : S_IDLE;
        end else if (rd_tag == omp_pkg::TC_OTHER) begin
          cur_inc = 1'b1;
          st_nxt  = S_LOOK;
        end else if (can_stage) begin
          push     = stg_valid;
          tok.emit = 1'b1;
          tok.kind = (rd_tag == omp_pkg::TC_TRUE)  ? omp_pkg::TK_TRUE :
                     (rd_tag == omp_pkg::TC_FALSE) ? omp_pkg::TK_FALSE :
                                                     omp_pkg::TK_NIL;
          cur_inc  = 1'b1;
          st_nxt   = S_LOOK;
        end
      end
      S_CLOSE: begin
        if (ph_r == omp_pkg::PH_SKIP) begin
          finish = 1'b1;
        end else if (can_stage) begin
          push     = stg_valid;
          tok.emit = 1'b1;
          if (ph_r == omp_pkg::PH_DONE) begin
            tok.kind = omp_pkg::TK_MSG_END; tok.use_total = 1'b1;
          end else begin
            tok.kind = omp_pkg::TK_ERROR;
          end
          finish = 1'b1;
        end
        if (finish) begin
          ph_nxt     = omp_pkg::PH_LEN;
          pos_nxt    = 2'd0;
          acc_clear  = 1'b1;
          tags_clear = 1'b1;
          close_nxt  = 1'b0;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ph_r    <= omp_pkg::PH_LEN;
      pos_r   <= 2'd0;
      close_r <= 1'b0;
      al_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      ph_r    <= ph_nxt;
      pos_r   <= pos_nxt;
      close_r <= close_nxt;
      al_r    <= al_nxt;
    end
  end
endmodule

[rtl/osc_message_parser_core.sv]
// Top level of the OSC message parser: controller plus datapath.
//
// channel | handshake              | contents
// in_     | in_tvalid, in_tready   | tdata[7:0] data_byte
// out_    | out_tvalid, out_tready | tuser[3:0] kind, tdata[31:0] value, [36:32] arg, tlast
//
// A byte's tokens pass a staging register, then the output register.
// A new byte is taken only in the idle state, when the staged token, if any, can move on.
// A blob end and a frame close each take one more controller state; the walk over
// payload-free tags passes a tag store read state, then a decode state, per tag.
// Reset is synchronous, active low. With a token staged, a stalled output holds the input.
module osc_message_parser_core #(
  parameter int MAX_TAGS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] token_value, [36:32] arg_number, [39:37] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);
  localparam int AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int CW = $clog2(MAX_TAGS + 1);

  logic acc_shift, acc_clear, len_load, bl_dec, blob_load, blob_dec;
  logic tags_clear, tag_push, cur_inc;
  logic push, push_last, stg_valid;
  logic [AW-1:0] rd_addr;
  omp_pkg::tok_cmd_t tok;
  logic [31:0] acc_next, bytes_left, blob_left;
  logic [CW-1:0] tag_total, tag_cursor;
  omp_pkg::tag_t rd_tag;
  logic out_free;
  logic [31:0] out_value;
  logic [4:0]  out_arg;

  assign out_free  = !out_tvalid || out_tready;
  assign out_tdata = {3'b000, out_arg, out_value};

  omp_ctrl #(.MAX_TAGS(MAX_TAGS), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .byte_i(in_tdata),
    .out_free, .stg_valid, .acc_next, .bytes_left, .blob_left, .tag_total, .tag_cursor,
    .rd_tag, .acc_shift, .acc_clear, .len_load, .bl_dec, .blob_load, .blob_dec,
    .tags_clear, .tag_push, .cur_inc, .rd_addr, .tok, .push, .push_last
  );

  omp_datapath #(.MAX_TAGS(MAX_TAGS), .AW(AW), .CW(CW)) u_dp (
    .clk, .rst_n, .byte_i(in_tdata), .acc_shift, .acc_clear, .len_load, .bl_dec,
    .blob_load, .blob_dec, .tags_clear, .tag_push, .cur_inc, .rd_addr, .tok,
    .push, .push_last, .out_take(out_tready), .acc_next, .bytes_left, .blob_left,
    .tag_total, .tag_cursor, .rd_tag, .stg_valid, .out_valid(out_tvalid),
    .out_kind(out_tuser), .out_value, .out_arg, .out_last(out_tlast)
  );
endmodule
